>>> sv/spt_pkg.sv
// Shared types and opcodes for the section time profiler.
`timescale 1ns / 1ps

package spt_pkg;

    // Opcodes carried in the input beat
    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_FINAL = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] timestamp;
        logic [3:0]  read_index;
    } t_in_beat;

    typedef struct packed {
        logic        ok;
        logic [31:0] bin_value;
        logic [31:0] total_ticks;
        logic [3:0]  highest_bin;
        logic [4:0]  current_bin;
    } t_out_beat;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch input beat, launch bin read
        logic commit;   // update state, load output register
    } t_cmd;

endpackage

>>> sv/section_time_profiler.sv
// Section time profiler top level: controller plus datapath.
// An accepted item is latched and its bin read (idle state), then committed
// to the output register (execute state), which waits while a finished
// result beat is held by backpressure; only one item is in flight at a time.
// Reset (i_rst_n, synchronous, active low) zeroes bins, total, reference time
// and both indices, and empties the output register.
`timescale 1ns / 1ps

module section_time_profiler #(
    parameter int NUM_BINS = 16     // 1 .. 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spt_pkg::t_in_beat  i_in_beat,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spt_pkg::t_out_beat o_out_beat
);

    // load:   beat accepted, item latched, bin addressed by the mark index
    //         (or read_index for reads) is read into a register
    // commit: state updated and result placed in the output register; waits
    //         while the previous result beat is still held downstream
    spt_pkg::t_cmd cmd;

    spt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Bins live in a single-write, registered-read memory. A per-bin valid
    // bit is cleared all at once by reset or a clear item, so a bin that was
    // not written since reads as zero.
    spt_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_beat  (i_in_beat),
        .o_out_beat (o_out_beat)
    );

`ifndef SYNTHESIS
    // one item in flight: no new accept in the cycle after a load
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // a commit always presents a result beat
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("commit without result beat");

    // load and commit never coincide
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.commit))
        else $error("load and commit in the same cycle");
`endif

endmodule

>>> sv/spt_ctrl.sv
// Controller FSM: input handshake, execute sequencing and output valid.
`timescale 1ns / 1ps

module spt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spt_pkg::t_cmd o_cmd
);

    spt_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            spt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = spt_pkg::S_EXEC;
                end
            end
            spt_pkg::S_EXEC: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = spt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/spt_datapath.sv
// Datapath: bin memory, totals, section indices and output register.
`timescale 1ns / 1ps

module spt_datapath #(
    parameter int NUM_BINS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spt_pkg::t_cmd      i_cmd,
    input  spt_pkg::t_in_beat  i_in_beat,
    output spt_pkg::t_out_beat o_out_beat
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int IW = $clog2(NUM_BINS + 1);

    // bin storage; r_valid marks entries written since the last clear
    logic [31:0]         r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_valid;

    // latched item
    logic [1:0]  r_op;
    logic [31:0] r_ts;
    logic        r_in_range;
    logic [31:0] r_rdata;
    logic        r_rd_valid;

    // profile state
    logic [31:0]   r_total, n_total;
    logic [31:0]   r_last, n_last;
    logic [IW-1:0] r_index, n_index;
    logic [AW-1:0] r_highest, n_highest;

    spt_pkg::t_out_beat r_out, n_out;

    logic [AW+3:0] ridx_ext;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          is_mark;
    logic          full;
    logic          do_write;
    logic [31:0]   bin_old;
    logic [31:0]   diff;
    logic [31:0]   sum;
    logic [IW+4:0] index_ext;
    logic [AW+3:0] highest_ext;

    assign ridx_ext = (AW + 4)'(i_in_beat.read_index);
    assign rd_addr  = (i_in_beat.opcode == spt_pkg::OP_READ) ? ridx_ext[AW-1:0]
                                                             : r_index[AW-1:0];
    assign wr_addr  = r_index[AW-1:0];

    // item latch and registered bin read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in_beat.opcode;
            r_ts       <= i_in_beat.timestamp;
            r_in_range <= (32'(i_in_beat.read_index) < 32'(NUM_BINS));
            r_rdata    <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_addr] <= sum;
        end
    end

    assign is_mark  = (r_op == spt_pkg::OP_MARK) || (r_op == spt_pkg::OP_FINAL);
    assign full     = (r_index == IW'(NUM_BINS));
    assign do_write = i_cmd.commit && is_mark && !full;
    assign bin_old  = r_rd_valid ? r_rdata : 32'd0;
    assign diff     = r_ts - r_last;
    assign sum      = bin_old + diff;

    always_comb begin
        n_total      = r_total;
        n_last       = r_last;
        n_index      = r_index;
        n_highest    = r_highest;
        n_out.ok        = 1'b1;
        n_out.bin_value = 32'd0;
        unique case (r_op) inside
            spt_pkg::OP_MARK, spt_pkg::OP_FINAL: begin
                if (full) begin
                    n_out.ok = 1'b0;
                end else begin
                    n_out.bin_value = sum;
                    n_total         = r_total + diff;
                    n_last          = r_ts;
                    n_index         = r_index + IW'(1);
                end
                if (r_op == spt_pkg::OP_FINAL) begin
                    // close the pass: highest is the bin just updated, or the last bin if full
                    n_highest = full ? AW'(NUM_BINS - 1) : r_index[AW-1:0];
                    n_index   = '0;
                end
            end
            spt_pkg::OP_CLEAR: begin
                n_total   = 32'd0;
                n_last    = r_ts;
                n_index   = '0;
                n_highest = '0;
            end
            default: begin
                n_out.bin_value = r_in_range ? bin_old : 32'd0;
            end
        endcase
        index_ext         = (IW + 5)'(n_index);
        highest_ext       = (AW + 4)'(n_highest);
        n_out.total_ticks = n_total;
        n_out.highest_bin = highest_ext[3:0];
        n_out.current_bin = index_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_total   <= 32'd0;
            r_last    <= 32'd0;
            r_index   <= '0;
            r_highest <= '0;
        end else if (i_cmd.commit) begin
            r_total   <= n_total;
            r_last    <= n_last;
            r_index   <= n_index;
            r_highest <= n_highest;
            if (r_op == spt_pkg::OP_CLEAR) begin
                r_valid <= '0;
            end else if (do_write) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_beat = r_out;

endmodule

>>> verif/section_time_profiler_chk.sv
// Scoreboard for the section time profiler: predicts every result beat and compares.
`timescale 1ns / 1ps

module section_time_profiler_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spt_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spt_pkg::t_out_beat i_out_beat,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_compared,
    output int                 o_refused
);
    localparam int NUM_BINS = 16;

    logic [31:0]        bin_ticks [NUM_BINS];
    logic [31:0]        sum_ticks;
    logic [31:0]        ref_time;
    logic [4:0]         sect_idx;
    logic [3:0]         top_sect;
    spt_pkg::t_out_beat awaited_beats [$];

    int fails = 0;
    int compared = 0;
    int refused = 0;
    int waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;
    assign o_compared   = compared;
    assign o_refused    = refused;

    // Close the open section at time now; refused once every bin is used.
    function automatic logic close_section(input logic [31:0] now, output logic [31:0] val);
        logic [31:0] delta;
        if (sect_idx >= NUM_BINS) begin
            val = '0;
            return 1'b0;
        end
        delta = now - ref_time;
        bin_ticks[sect_idx[3:0]] = bin_ticks[sect_idx[3:0]] + delta;
        val = bin_ticks[sect_idx[3:0]];
        sum_ticks = sum_ticks + delta;
        ref_time = now;
        sect_idx = sect_idx + 5'd1;
        return 1'b1;
    endfunction

    function automatic spt_pkg::t_out_beat profile_step(input spt_pkg::t_in_beat b);
        spt_pkg::t_out_beat r;
        logic [31:0]        val;
        logic               ok;
        val = '0;
        ok  = 1'b1;
        case (b.opcode)
            spt_pkg::OP_MARK: begin
                ok = close_section(b.timestamp, val);
            end
            spt_pkg::OP_FINAL: begin
                ok = close_section(b.timestamp, val);
                // index 16 (full) wraps to 15 here, as intended
                top_sect = (sect_idx != 5'd0) ? sect_idx[3:0] - 4'd1 : 4'd0;
                sect_idx = '0;
            end
            spt_pkg::OP_CLEAR: begin
                for (int k = 0; k < NUM_BINS; k++) bin_ticks[k] = '0;
                sum_ticks = '0;
                sect_idx  = '0;
                top_sect  = '0;
                ref_time  = b.timestamp;
            end
            spt_pkg::OP_READ: begin
                val = bin_ticks[b.read_index];
            end
        endcase
        r.ok          = ok;
        r.bin_value   = val;
        r.total_ticks = sum_ticks;
        r.highest_bin = top_sect;
        r.current_bin = sect_idx;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        spt_pkg::t_out_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++) bin_ticks[k] = '0;
            sum_ticks = '0;
            ref_time  = '0;
            sect_idx  = '0;
            top_sect  = '0;
            awaited_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_beats.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat with nothing expected: %h", $realtime,
                                 i_out_beat);
                end else begin
                    want = awaited_beats.pop_front();
                    compared++;
                    if (i_out_beat !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch exp ok=%b bin=%h total=%h hi=%0d cur=%0d",
                                     $realtime, want.ok, want.bin_value, want.total_ticks,
                                     want.highest_bin, want.current_bin);
                            $display("           got ok=%b bin=%h total=%h hi=%0d cur=%0d",
                                     i_out_beat.ok, i_out_beat.bin_value,
                                     i_out_beat.total_ticks, i_out_beat.highest_bin,
                                     i_out_beat.current_bin);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = profile_step(i_in_beat);
                if (!want.ok) refused++;
                awaited_beats.push_back(want);
            end
        end
        waiting = awaited_beats.size();
    end

endmodule

>>> verif/section_time_profiler_tb.sv
// Testbench top for the section time profiler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module section_time_profiler_tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    spt_pkg::t_in_beat  i_in_beat;
    logic               o_out_valid;
    logic               i_out_ready;
    spt_pkg::t_out_beat o_out_beat;

    int fail_count;
    int pending;
    int compared;
    int refused;

    // Idle odds in percent for each side; dropped to zero for one long stretch.
    int in_idle_pct   = 16;
    int out_stall_pct = 16;

    int          beats_sent = 0;
    int          op_seen [4] = '{default: 0};
    bit          drained_midway = 1'b0;
    logic [31:0] tick_now;

    section_time_profiler #(.NUM_BINS(16)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    // Checker sits beside the block and sees both channels as they are.
    section_time_profiler_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_beat   (o_out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_refused    (refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Safety net: far beyond the slowest legal run (~800 beats, plus stalls
    // on both sides).
    initial begin
        #5_000_000;
        $display("section_time_profiler_tb: done, errors");
        $finish;
    end

    // Result side backpressure, re-rolled every cycle at the falling edge.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    function automatic spt_pkg::t_in_beat make_beat(input logic [1:0] op,
                                                    input logic [31:0] ts,
                                                    input logic [3:0] idx);
        spt_pkg::t_in_beat b;
        b.opcode     = op;
        b.timestamp  = ts;
        b.read_index = idx;
        return b;
    endfunction

    // Free-running time: mostly short sections, now and then a long one or a
    // jump anywhere in the 32-bit range (which also exercises wraparound).
    function automatic logic [31:0] next_tick();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            tick_now = tick_now + $urandom_range(0, 2000);
        else if (roll < 95)
            tick_now = tick_now + $urandom_range(0, 32'h00FF_FFFF);
        else
            tick_now = $urandom;
        return tick_now;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_beat(input spt_pkg::t_in_beat b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
        op_seen[b.opcode]++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // One profiling pass as instrumented code would produce it: optional clear,
    // a run of marks (sometimes past the last bin), reads sprinkled in, and
    // usually a closing final mark.
    task automatic section_pass();
        int n_marks;
        if ($urandom_range(0, 99) < 30)
            push_beat(make_beat(spt_pkg::OP_CLEAR, next_tick(), 4'($urandom)));
        n_marks = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
        for (int k = 0; k < n_marks; k++) begin
            if ($urandom_range(0, 3) == 0)
                push_beat(make_beat(spt_pkg::OP_READ, $urandom, 4'($urandom_range(0, 15))));
            push_beat(make_beat(spt_pkg::OP_MARK, next_tick(), 4'($urandom)));
        end
        if ($urandom_range(0, 9) != 0)
            push_beat(make_beat(spt_pkg::OP_FINAL, next_tick(), 4'($urandom)));
        if ($urandom_range(0, 1) == 0)
            push_beat(make_beat(spt_pkg::OP_READ, $urandom, 4'($urandom_range(0, 15))));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat  = '0;
        tick_now   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed beats ---
        // bin still empty after reset
        push_beat(make_beat(spt_pkg::OP_READ, 32'hFFFF_FFFF, 4'd0));
        push_beat(make_beat(spt_pkg::OP_MARK, 32'h0000_0000, 4'hF));   // zero elapsed
        push_beat(make_beat(spt_pkg::OP_MARK, 32'hFFFF_FFFF, 4'h0));   // largest elapsed
        push_beat(make_beat(spt_pkg::OP_FINAL, 32'd5, 4'hA));          // elapsed wraps past zero
        // new reference mid-range
        push_beat(make_beat(spt_pkg::OP_CLEAR, 32'h8000_0000, 4'h5));
        tick_now = 32'h8000_0000;
        // fill all sixteen bins; last one long enough to wrap the total
        for (int k = 0; k < 16; k++) begin
            tick_now = tick_now + ((k == 15) ? 32'hFFFF_FFF0 : 32'(k * 37 + 1));
            push_beat(make_beat(spt_pkg::OP_MARK, tick_now, k[3:0]));
        end
        // index full: refused
        push_beat(make_beat(spt_pkg::OP_MARK, tick_now + 32'd100, 4'h3));
        // refused, loop still closes
        push_beat(make_beat(spt_pkg::OP_FINAL, tick_now + 32'd200, 4'hC));
        push_beat(make_beat(spt_pkg::OP_READ, 32'h0, 4'hF));
        push_beat(make_beat(spt_pkg::OP_READ, 32'h0, 4'h0));

        drain_results();

        // --- random beats ---
        while (beats_sent < 775) begin
            if (beats_sent >= 300 && beats_sent < 450) begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end else begin
                in_idle_pct   = 16;
                out_stall_pct = 16;
            end
            if (!drained_midway && beats_sent >= 500) begin
                drain_results();
                drained_midway = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
                section_pass();
            else
                push_beat(make_beat(2'($urandom_range(0, 3)), $urandom,
                                    4'($urandom_range(0, 15))));
        end
        i_in_valid <= 1'b0;

        // Let the last results come home, then keep watching for strays.
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d beats: %0d mark, %0d final, %0d clear, %0d read",
                 beats_sent, op_seen[spt_pkg::OP_MARK], op_seen[spt_pkg::OP_FINAL],
                 op_seen[spt_pkg::OP_CLEAR], op_seen[spt_pkg::OP_READ]);
        $display("%0d results compared, %0d marks refused on a full index", compared, refused);
        if (fail_count == 0 && pending == 0)
            $display("section_time_profiler_tb: done, clean");
        else
            $display("section_time_profiler_tb: done, errors");
        $finish;
    end

endmodule

>>> section_time_profiler.f
sv/spt_pkg.sv
sv/spt_ctrl.sv
sv/spt_datapath.sv
sv/section_time_profiler.sv
verif/section_time_profiler_chk.sv
verif/section_time_profiler_tb.sv
